// File: rtl/pgn_pkg.sv
// ============================================================================
// pgn_pkg - shared types and constants of the polar gaussian noise pair unit
// Holds the request records passed between the front end, the request queue
// and the two back-end pipelines, plus fixed-point constants.
// ============================================================================
`default_nettype none

package pgn_pkg;

    // Default parameter values
    localparam int UNIFORM_BITS_DEF = 32;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Scale register
    localparam int               SCALE_BITS        = 16;
    localparam logic [SCALE_BITS-1:0] NOISE_SCALE_RESET = 16'd4096;

    // Fixed-point constants
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [63:0] R2_ONE      = 64'h4000_0000_0000_0000;
    localparam logic [31:0] HALF_Q32    = 32'h8000_0000;
    localparam int          LOG_STEPS   = 32;
    localparam int          QUEUE_DEPTH = 4;

    // Sign and magnitude of both folded samples
    typedef struct packed {
        logic        neg_a;
        logic        neg_b;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
    } pgn_side_t;

    // Accepted request after classification
    typedef struct packed {
        pgn_side_t   side;
        logic [62:0] r2;
    } pgn_item_t;

    // Log pipeline result
    typedef struct packed {
        pgn_side_t   side;
        logic [31:0] mant;
        logic [5:0]  shift;
        logic [38:0] lnv;
    } pgn_log_t;

endpackage

`default_nettype wire

// File: rtl/pgn_front.sv
// ============================================================================
// pgn_front - request front end
// Folds both uniforms into sign and Q1.31 magnitude, squares them and drops
// pairs that fall outside the unit circle or on its center.
// ============================================================================
`default_nettype none

module pgn_front #(
    parameter int UNIFORM_BITS = pgn_pkg::UNIFORM_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [31:0]        uniform_a,
    input  wire logic [31:0]        uniform_b,
    input  wire logic               full,
    output logic                    push,
    output pgn_pkg::pgn_item_t      push_item
);
    import pgn_pkg::*;

    logic        valid1_reg;
    logic        valid2_reg;
    pgn_side_t   s1_reg;
    pgn_side_t   s2_reg;
    pgn_side_t   s1_next;
    logic [62:0] sq_a_reg;
    logic [62:0] sq_b_reg;
    logic [31:0] u_a;
    logic [31:0] u_b;
    logic [63:0] sq_a_full;
    logic [63:0] sq_b_full;
    logic [63:0] r2_sum;
    logic        keep;
    logic        hold;

    // Align the uniforms to 32 bits and fold around one half
    assign u_a = 32'(uniform_a[UNIFORM_BITS-1:0]) << (32 - UNIFORM_BITS);
    assign u_b = 32'(uniform_b[UNIFORM_BITS-1:0]) << (32 - UNIFORM_BITS);

    always_comb
    begin
        s1_next.neg_a = ~u_a[31];
        s1_next.neg_b = ~u_b[31];
        s1_next.mag_a = u_a[31] ? {1'b0, u_a[30:0]} : HALF_Q32 - u_a;
        s1_next.mag_b = u_b[31] ? {1'b0, u_b[30:0]} : HALF_Q32 - u_b;
    end

    assign sq_a_full = s1_reg.mag_a * s1_reg.mag_a;
    assign sq_b_full = s1_reg.mag_b * s1_reg.mag_b;

    // Classify: keep only 0 < r2 <= 1
    assign r2_sum = {1'b0, sq_a_reg} + {1'b0, sq_b_reg};
    assign keep   = (r2_sum <= R2_ONE) && (r2_sum != '0);
    assign hold   = valid2_reg && keep && full;
    assign push   = valid2_reg && keep && !full;

    assign in_stall       = hold;
    assign push_item.side = s2_reg;
    assign push_item.r2   = r2_sum[62:0];

    // Advance the valid flags unless the queue blocks a kept request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (!hold)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s1_reg;
            sq_a_reg <= sq_a_full[62:0];
            sq_b_reg <= sq_b_full[62:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/pgn_queue.sv
// ============================================================================
// pgn_queue - request queue
// Short first-in first-out buffer between the front end and the back end.
// ============================================================================
`default_nettype none

module pgn_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  pgn_pkg::pgn_item_t      push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output pgn_pkg::pgn_item_t      head_item
);
    import pgn_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pgn_item_t        entry_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill level beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// File: rtl/pgn_log.sv
// ============================================================================
// pgn_log - normalize and logarithm pipeline
// Normalizes r2 to a Q1.31 mantissa, takes the log2 fraction by repeated
// squaring and forms -2 ln(r2) in Q32.
// ============================================================================
`default_nettype none

module pgn_log (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  pgn_pkg::pgn_item_t      in_item,
    output logic                    out_valid,
    output pgn_pkg::pgn_log_t       out_data
);
    import pgn_pkg::*;

    localparam int NORM_STAGES = 6;
    localparam int STAGES      = NORM_STAGES + LOG_STEPS + 2;

    logic [STAGES-1:0] valid_reg;
    pgn_side_t         side_reg [0:STAGES-1];
    logic [62:0]       nv_reg   [0:NORM_STAGES-1];
    logic [5:0]        nlz_reg  [0:NORM_STAGES-1];
    logic [31:0]       lm_reg   [0:LOG_STEPS-1];
    logic [31:0]       lf_reg   [0:LOG_STEPS-1];
    logic [5:0]        llz_reg  [0:LOG_STEPS-1];
    logic [31:0]       lmant_reg [0:LOG_STEPS-1];
    logic [37:0]       t_full;
    logic [29:0]       t_reg;
    logic [31:0]       t_m_reg;
    logic [5:0]        t_lz_reg;
    logic [61:0]       a_prod;
    logic [38:0]       a_reg;
    logic [31:0]       a_m_reg;
    logic [5:0]        a_lz_reg;

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // Carry signs and magnitudes alongside
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_item.side;
            for (int i = 1; i < STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Normalize: shift out leading zeros in halving steps
    for (genvar j = 0; j < NORM_STAGES; j++)
    begin : g_norm
        localparam int SH = 32 >> j;
        logic [62:0] v_in;
        logic [5:0]  lz_in;
        logic        zero;

        if (j == 0)
        begin : g_first
            assign v_in  = in_item.r2;
            assign lz_in = '0;
        end
        else
        begin : g_rest
            assign v_in  = nv_reg[j-1];
            assign lz_in = nlz_reg[j-1];
        end

        assign zero = (v_in[62 -: SH] == '0);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                nv_reg[j]  <= zero ? (v_in << SH) : v_in;
                nlz_reg[j] <= zero ? lz_in + 6'(SH) : lz_in;
            end
        end
    end

    // Log2 fraction: one squaring per stage, one result bit each
    for (genvar k = 0; k < LOG_STEPS; k++)
    begin : g_log
        logic [31:0] m_in;
        logic [31:0] f_in;
        logic [5:0]  lz_in;
        logic [31:0] mm_in;
        logic [63:0] sq;
        logic [32:0] mn;

        if (k == 0)
        begin : g_first
            assign m_in  = nv_reg[NORM_STAGES-1][62:31];
            assign f_in  = '0;
            assign lz_in = nlz_reg[NORM_STAGES-1];
            assign mm_in = nv_reg[NORM_STAGES-1][62:31];
        end
        else
        begin : g_rest
            assign m_in  = lm_reg[k-1];
            assign f_in  = lf_reg[k-1];
            assign lz_in = llz_reg[k-1];
            assign mm_in = lmant_reg[k-1];
        end

        assign sq = m_in * m_in;
        assign mn = sq[63:31];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lm_reg[k]    <= mn[32] ? mn[32:1] : mn[31:0];
                lf_reg[k]    <= {f_in[30:0], mn[32]};
                llz_reg[k]   <= lz_in;
                lmant_reg[k] <= mm_in;
            end
        end
    end

    // Form -log2(r2) and scale by ln2
    assign t_full = {llz_reg[LOG_STEPS-1], 32'b0} - {6'b0, lf_reg[LOG_STEPS-1]};
    assign a_prod = t_reg * LN2_Q32;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg    <= t_full[37:8];
            t_m_reg  <= lmant_reg[LOG_STEPS-1];
            t_lz_reg <= llz_reg[LOG_STEPS-1];
            a_reg    <= a_prod[61:23];
            a_m_reg  <= t_m_reg;
            a_lz_reg <= t_lz_reg;
        end
    end

    assign out_valid      = valid_reg[STAGES-1];
    assign out_data.side  = side_reg[STAGES-1];
    assign out_data.mant  = a_m_reg;
    assign out_data.shift = a_lz_reg;
    assign out_data.lnv   = a_reg;

    a_norm_top: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NORM_STAGES-1] |-> nv_reg[NORM_STAGES-1][62])
        else $error("mantissa not normalized");

endmodule

`default_nettype wire

// File: rtl/pgn_root.sv
// ============================================================================
// pgn_root - divide, square root and sample mapping pipeline
// Divides -2 ln(r2) by the mantissa, takes the square root, multiplies by
// each magnitude, applies sigma and saturates to the sample format.
// ============================================================================
`default_nettype none

module pgn_root #(
    parameter int SAMPLE_BITS = pgn_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_valid,
    input  pgn_pkg::pgn_log_t                        in_data,
    input  wire logic [pgn_pkg::SCALE_BITS-1:0]      scale,
    output logic                                     out_valid,
    output logic [SAMPLE_BITS-1:0]                   sample_a,
    output logic [SAMPLE_BITS-1:0]                   sample_b,
    output logic                                     clip
);
    import pgn_pkg::*;

    localparam int DIV_STEPS  = 33;
    localparam int ROOT_STEPS = 20;
    localparam int SQW        = 42;
    localparam int ROOT_BASE  = DIV_STEPS + 1;
    localparam int PROD_IDX   = ROOT_BASE + ROOT_STEPS;
    localparam int SCALE_IDX  = PROD_IDX + 2;
    localparam int STAGES     = SCALE_IDX + 2;
    localparam int PW         = 40 + SAMPLE_BITS - 1;
    localparam int MW         = PW - 33;
    localparam logic [MW-1:0] SMAX = MW'((1 << (SAMPLE_BITS - 1)) - 1);

    logic [STAGES-1:0]        valid_reg;
    pgn_side_t                side_reg [0:SCALE_IDX];
    logic [31:0]              dr_reg   [0:DIV_STEPS-1];
    logic [32:0]              dq_reg   [0:DIV_STEPS-1];
    logic [31:0]              dm_reg   [0:DIV_STEPS-1];
    logic [38:0]              da_reg   [0:DIV_STEPS-1];
    logic [5:0]               ds_reg   [0:DIV_STEPS-1];
    logic [39:0]              adj_v_reg;
    logic [4:0]               adj_h_reg;
    logic [5:0]               adj_s;
    logic [SQW-1:0]           sv_reg   [0:ROOT_STEPS-1];
    logic [SQW-1:0]           sr_reg   [0:ROOT_STEPS-1];
    logic [4:0]               sh_reg   [0:ROOT_STEPS-1];
    logic [19:0]              root;
    logic [51:0]              pa_reg;
    logic [51:0]              pb_reg;
    logic [4:0]               p_h_reg;
    logic [23:0]              ya_reg;
    logic [23:0]              yb_reg;
    logic [39:0]              ysa_reg;
    logic [39:0]              ysb_reg;
    logic [SAMPLE_BITS:0]     map_a;
    logic [SAMPLE_BITS:0]     map_b;
    logic [SAMPLE_BITS-1:0]   sample_a_reg;
    logic [SAMPLE_BITS-1:0]   sample_b_reg;
    logic                     clip_reg;

    // Scale the product by 2^h, drop 27 fraction bits, clamp to 24 bits
    function automatic logic [23:0] clamp_y(input logic [51:0] p, input logic [4:0] h);
        logic [82:0] w;
        w = 83'(p) << h;
        return (w[82:51] != '0) ? 24'hFF_FFFF : w[50:27];
    endfunction

    // Map to sample format, truncate toward zero and saturate
    function automatic logic [SAMPLE_BITS:0] map_sample(input logic neg,
                                                        input logic [39:0] ys);
        logic [PW-1:0]          prod;
        logic [MW-1:0]          mag;
        logic [MW-1:0]          lim;
        logic                   rem;
        logic                   sat;
        logic [SAMPLE_BITS-1:0] mag_s;
        prod  = (PW'(ys) << (SAMPLE_BITS - 1)) - PW'(ys);
        mag   = prod[PW-1:33];
        rem   = (prod[32:0] != '0);
        lim   = neg ? SMAX + 1'b1 : SMAX;
        sat   = (mag > lim) || ((mag == lim) && rem);
        mag_s = sat ? lim[SAMPLE_BITS-1:0] : mag[SAMPLE_BITS-1:0];
        return {sat, neg ? -mag_s : mag_s};
    endfunction

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // Carry signs and magnitudes alongside
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_data.side;
            for (int i = 1; i <= SCALE_IDX; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Restoring divide of (lnv << 25) by the mantissa, one quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        localparam int BIT = DIV_STEPS - 1 - i;
        logic [31:0] r_in;
        logic [32:0] q_in;
        logic [31:0] m_in;
        logic [38:0] a_in;
        logic [5:0]  s_in;
        logic        dbit;
        logic [32:0] trial;
        logic [32:0] diff;
        logic        ge;

        if (i == 0)
        begin : g_first
            assign r_in = {1'b0, in_data.lnv[38:8]};
            assign q_in = '0;
            assign m_in = in_data.mant;
            assign a_in = in_data.lnv;
            assign s_in = in_data.shift;
        end
        else
        begin : g_rest
            assign r_in = dr_reg[i-1];
            assign q_in = dq_reg[i-1];
            assign m_in = dm_reg[i-1];
            assign a_in = da_reg[i-1];
            assign s_in = ds_reg[i-1];
        end

        if (BIT >= 25)
        begin : g_dbit
            assign dbit = a_in[BIT-25];
        end
        else
        begin : g_dzero
            assign dbit = 1'b0;
        end

        assign trial = {r_in, dbit};
        assign diff  = trial - {1'b0, m_in};
        assign ge    = (trial >= {1'b0, m_in});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dr_reg[i] <= ge ? diff[31:0] : trial[31:0];
                dq_reg[i] <= {q_in[31:0], ge};
                dm_reg[i] <= m_in;
                da_reg[i] <= a_in;
                ds_reg[i] <= s_in;
            end
        end
    end

    // Make the exponent even and form the radicand
    assign adj_s = ds_reg[DIV_STEPS-1] - {5'b0, ds_reg[DIV_STEPS-1][0]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            adj_v_reg <= ds_reg[DIV_STEPS-1][0] ? {dq_reg[DIV_STEPS-1], 1'b0, 6'b0}
                                                : {1'b0, dq_reg[DIV_STEPS-1], 6'b0};
            adj_h_reg <= adj_s[5:1];
        end
    end

    // Integer square root, one result bit per stage
    for (genvar i = 0; i < ROOT_STEPS; i++)
    begin : g_root
        localparam logic [SQW-1:0] RBIT = SQW'(1) << (2 * (ROOT_STEPS - 1 - i));
        logic [SQW-1:0] v_in;
        logic [SQW-1:0] r_in;
        logic [4:0]     h_in;
        logic [SQW-1:0] trial;
        logic           ge;

        if (i == 0)
        begin : g_first
            assign v_in = SQW'(adj_v_reg);
            assign r_in = '0;
            assign h_in = adj_h_reg;
        end
        else
        begin : g_rest
            assign v_in = sv_reg[i-1];
            assign r_in = sr_reg[i-1];
            assign h_in = sh_reg[i-1];
        end

        assign trial = r_in + RBIT;
        assign ge    = (v_in >= trial);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sv_reg[i] <= ge ? v_in - trial : v_in;
                sr_reg[i] <= ge ? (r_in >> 1) + RBIT : (r_in >> 1);
                sh_reg[i] <= h_in;
            end
        end
    end

    assign root  = sr_reg[ROOT_STEPS-1][19:0];
    assign map_a = map_sample(side_reg[SCALE_IDX].neg_a, ysa_reg);
    assign map_b = map_sample(side_reg[SCALE_IDX].neg_b, ysb_reg);

    // Multiply, shift, scale and map
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg       <= side_reg[PROD_IDX-1].mag_a * root;
            pb_reg       <= side_reg[PROD_IDX-1].mag_b * root;
            p_h_reg      <= sh_reg[ROOT_STEPS-1];
            ya_reg       <= clamp_y(pa_reg, p_h_reg);
            yb_reg       <= clamp_y(pb_reg, p_h_reg);
            ysa_reg      <= ya_reg * scale;
            ysb_reg      <= yb_reg * scale;
            sample_a_reg <= map_a[SAMPLE_BITS-1:0];
            sample_b_reg <= map_b[SAMPLE_BITS-1:0];
            clip_reg     <= map_a[SAMPLE_BITS] | map_b[SAMPLE_BITS];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign sample_a  = sample_a_reg;
    assign sample_b  = sample_b_reg;
    assign clip      = clip_reg;

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[DIV_STEPS-1] |-> (dr_reg[DIV_STEPS-1] < dm_reg[DIV_STEPS-1]))
        else $error("divider remainder not below divisor");
    a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[PROD_IDX-1] |-> (sr_reg[ROOT_STEPS-1][SQW-1:20] == '0))
        else $error("square root wider than 20 bits");

endmodule

`default_nettype wire

// File: rtl/polar_gaussian_noise_pair_unit.sv
// ============================================================================
// polar_gaussian_noise_pair_unit - polar-method gaussian noise pair generator
// Throughput: one uniform pair per cycle while in_stall is low; rejected
//   pairs give no result. The back end holds 32-step log, 33-step divide
//   and 20-step root pipelines.
// Reset: clears all valid flags and the queue, sets sigma to 0.5; no clear pass.
// ============================================================================
`default_nettype none

module polar_gaussian_noise_pair_unit #(
    parameter int UNIFORM_BITS = pgn_pkg::UNIFORM_BITS_DEF,
    parameter int SAMPLE_BITS  = pgn_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [31:0]                     uniform_a,
    input  wire logic [31:0]                     uniform_b,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pgn_pkg::SCALE_BITS-1:0]  noise_scale,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [SAMPLE_BITS-1:0]        noise_real,
    output logic signed [SAMPLE_BITS-1:0]        noise_imag,
    output logic                                 clipped
);
    import pgn_pkg::*;

    logic [SCALE_BITS-1:0] noise_scale_reg;
    logic                  adv;
    logic                  q_push;
    logic                  q_full;
    logic                  q_valid;
    pgn_item_t             q_push_item;
    pgn_item_t             q_head;
    logic                  log_valid;
    pgn_log_t              log_data;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;

    // Hold sigma
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_scale_reg <= NOISE_SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            noise_scale_reg <= noise_scale;
        end
    end

    // Advance the back end unless a result waits
    assign adv = !out_valid || !out_stall;

    pgn_front #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .uniform_a (uniform_a),
        .uniform_b (uniform_b),
        .full      (q_full),
        .push      (q_push),
        .push_item (q_push_item)
    );

    pgn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (adv && q_valid),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    pgn_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (q_valid),
        .in_item   (q_head),
        .out_valid (log_valid),
        .out_data  (log_data)
    );

    pgn_root #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (log_valid),
        .in_data   (log_data),
        .scale     (noise_scale_reg),
        .out_valid (out_valid),
        .sample_a  (sample_a),
        .sample_b  (sample_b),
        .clip      (clipped)
    );

    assign noise_real = sample_a;
    assign noise_imag = sample_b;

endmodule

`default_nettype wire
